// ----- rtl/mlf_pkg.sv -----
`default_nettype none
package mlf_pkg;

  localparam int BLOCK_LEN_DEF       = 256;
  localparam int UPDATE_INTERVAL_DEF = 10;

  localparam int DW    = 18;
  localparam int CW    = 15;
  localparam int CFG_AW = 1;
  localparam int W     = 40;
  localparam int MW    = 27;
  localparam int PW    = 2 * MW;
  localparam int SW    = 5;

  localparam logic [CFG_AW-1:0] REG_CUTOFF    = 1'd0;
  localparam logic [CFG_AW-1:0] REG_RESONANCE = 1'd1;

  localparam logic signed [W-1:0] ONE_Q14  = 40'sd16384;
  localparam logic signed [MW-1:0] K_POINT8 = 27'sd13107;
  localparam logic signed [MW-1:0] K_FIVE6  = 27'sd91750;
  localparam logic signed [MW-1:0] K_SIXTH  = 27'sd2731;
  localparam logic signed [DW-1:0] PREV_RST = 18'sd1638;
  localparam logic [CW-1:0] CUTOFF_RST = 15'd8192;

  localparam logic [SW-1:0] STEP_C0  = 5'd0;
  localparam logic [SW-1:0] STEP_C1  = 5'd1;
  localparam logic [SW-1:0] STEP_C2  = 5'd2;
  localparam logic [SW-1:0] STEP_C3  = 5'd3;
  localparam logic [SW-1:0] STEP_C4  = 5'd4;
  localparam logic [SW-1:0] STEP_C5  = 5'd5;
  localparam logic [SW-1:0] STEP_C6  = 5'd6;
  localparam logic [SW-1:0] STEP_FB  = 5'd7;
  localparam logic [SW-1:0] STEP_X   = 5'd8;
  localparam logic [SW-1:0] STEP_1A  = 5'd9;
  localparam logic [SW-1:0] STEP_1B  = 5'd10;
  localparam logic [SW-1:0] STEP_1C  = 5'd11;
  localparam logic [SW-1:0] STEP_2A  = 5'd12;
  localparam logic [SW-1:0] STEP_2B  = 5'd13;
  localparam logic [SW-1:0] STEP_2C  = 5'd14;
  localparam logic [SW-1:0] STEP_3A  = 5'd15;
  localparam logic [SW-1:0] STEP_3B  = 5'd16;
  localparam logic [SW-1:0] STEP_3C  = 5'd17;
  localparam logic [SW-1:0] STEP_4A  = 5'd18;
  localparam logic [SW-1:0] STEP_4B  = 5'd19;
  localparam logic [SW-1:0] STEP_4C  = 5'd20;
  localparam logic [SW-1:0] STEP_KA  = 5'd21;
  localparam logic [SW-1:0] STEP_KB  = 5'd22;
  localparam logic [SW-1:0] STEP_KC  = 5'd23;
  localparam logic [SW-1:0] STEP_KD  = 5'd24;
  localparam logic [SW-1:0] STEP_FIN = 5'd25;

  typedef struct packed {
    logic          load;
    logic          run;
    logic [SW-1:0] step;
    logic          commit;
  } mlf_cmd_t;

  typedef struct packed {
    logic upd_now;
  } mlf_stat_t;

  function automatic logic signed [DW-1:0] sat18(input logic signed [W-1:0] x);
    logic signed [DW-1:0] y;
    if (x > 40'sd131071) y = 18'sd131071;
    else if (x < -40'sd131072) y = -18'sd131072;
    else y = x[DW-1:0];
    return y;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/mlf_ctrl.sv -----
`default_nettype none
module mlf_ctrl
  import mlf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire mlf_stat_t stat,
  output mlf_cmd_t       cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic          state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept, commit;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign commit    = (state_r == ST_RUN) && (step_r == STEP_FIN) &&
                     (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_RUN;
          step_nxt  = stat.upd_now ? STEP_C0 : STEP_FB;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_FIN) begin
          if (commit) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_C0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.load   = accept;
  assign cmd.run    = (state_r == ST_RUN);
  assign cmd.step   = step_r;
  assign cmd.commit = commit;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r <= STEP_FIN))
    else $error("step beyond end of sequence");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_RUN) && (step_r == STEP_C0 || step_r == STEP_FB))
    else $error("bad start step");
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && (state_r == ST_IDLE))
    else $error("commit did not present result");

endmodule
`default_nettype wire

// ----- rtl/mlf_datapath.sv -----
`default_nettype none
module mlf_datapath
  import mlf_pkg::*;
#(
  parameter int BLOCK_LEN       = BLOCK_LEN_DEF,
  parameter int UPDATE_INTERVAL = UPDATE_INTERVAL_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_AW-1:0]    cfg_addr,
  input  wire logic [CW-1:0]        cfg_wdata,
  input  wire logic signed [DW-1:0] in_sample_in,
  input  wire logic signed [DW-1:0] in_cutoff_cv,
  input  wire logic signed [DW-1:0] in_emphasis_cv,
  input  wire mlf_cmd_t             cmd,
  output mlf_stat_t                 stat,
  output logic signed [DW-1:0]      out_lowpass_out,
  output logic signed [DW-1:0]      out_bandpass_out,
  output logic signed [DW-1:0]      out_highpass_out
);

  localparam int BPW = $clog2(BLOCK_LEN + 1);
  localparam int UPW = $clog2(UPDATE_INTERVAL + 1);

  logic [CW-1:0] cutoff_r, resonance_r;
  logic signed [DW-1:0] smp_r, ccv_r, ecv_r;
  logic signed [DW-1:0] prev_r, st1_r, st2_r, st3_r, st4_r;
  logic signed [DW-1:0] gain_r, fb_r, decay_r;
  logic signed [DW-1:0] x_r, ns1_r, ns2_r, ns3_r, ns4_r;
  logic signed [W-1:0]  fc_r, rr_r, base_r, pc_r, t_r;
  logic signed [PW-1:0] prod_r;
  logic [BPW-1:0] bpos_r, bpos_inc;
  logic [UPW-1:0] uph_r, uph_inc;
  logic signed [DW-1:0] lp_r, bp_r, hp_r;

  logic signed [W-1:0]  mq, sum, fcw, xw, qw;
  logic signed [MW-1:0] mul_a, mul_b;

  assign mq = prod_r[PW-1:14];
  assign stat.upd_now = (uph_r == '0);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.step)
      STEP_C1: begin mul_a = MW'(fc_r); mul_b = MW'(rr_r); end
      STEP_C2: begin mul_a = MW'(mq);   mul_b = K_POINT8; end
      STEP_C3: begin mul_a = MW'(rr_r); mul_b = MW'(rr_r); end
      STEP_C4: begin mul_a = MW'(mq);   mul_b = K_FIVE6; end
      STEP_C5: begin mul_a = MW'(rr_r); mul_b = MW'(ONE_Q14 - rr_r + mq); end
      STEP_FB: begin mul_a = MW'(fb_r); mul_b = MW'(st4_r); end
      STEP_1A: begin mul_a = MW'(x_r) + MW'(prev_r); mul_b = MW'(gain_r); end
      STEP_1B: begin mul_a = MW'(st1_r); mul_b = MW'(decay_r); end
      STEP_2A: begin mul_a = MW'(ns1_r) + MW'(st1_r); mul_b = MW'(gain_r); end
      STEP_2B: begin mul_a = MW'(st2_r); mul_b = MW'(decay_r); end
      STEP_3A: begin mul_a = MW'(ns2_r) + MW'(st2_r); mul_b = MW'(gain_r); end
      STEP_3B: begin mul_a = MW'(st3_r); mul_b = MW'(decay_r); end
      STEP_4A: begin mul_a = MW'(ns3_r) + MW'(st3_r); mul_b = MW'(gain_r); end
      STEP_4B: begin mul_a = MW'(st4_r); mul_b = MW'(decay_r); end
      STEP_KA: begin mul_a = MW'(ns4_r); mul_b = MW'(ns4_r); end
      STEP_KB: begin mul_a = MW'(mq);    mul_b = MW'(ns4_r); end
      STEP_KC: begin mul_a = MW'(mq);    mul_b = K_SIXTH; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sum = W'($signed({1'b0, cutoff_r})) + W'(ccv_r);
  assign fcw = (sum < 0) ? '0 : (sum >>> 2);
  assign xw  = W'(smp_r) - mq;
  assign qw  = base_r + ONE_Q14 + (mq >>> 1);
  assign bpos_inc = bpos_r + 1'b1;
  assign uph_inc  = uph_r + 1'b1;

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (cmd.load) begin
      smp_r <= in_sample_in;
      ccv_r <= in_cutoff_cv;
      ecv_r <= in_emphasis_cv;
    end
    if (cmd.run) begin
      case (cmd.step)
        STEP_C0: begin
          fc_r   <= fcw;
          rr_r   <= ONE_Q14 - fcw;
          base_r <= 40'sd6 * (W'($signed({1'b0, resonance_r})) + W'(ecv_r))
                    - 40'sd49152;
        end
        STEP_C3: pc_r <= fc_r + mq;
        STEP_X: begin
          if (xw > ONE_Q14) x_r <= 18'sd16384;
          else if (xw < -ONE_Q14) x_r <= -18'sd16384;
          else x_r <= xw[DW-1:0];
        end
        STEP_1B, STEP_2B, STEP_3B, STEP_4B: t_r <= mq;
        STEP_1C: ns1_r <= sat18(t_r - mq);
        STEP_2C: ns2_r <= sat18(t_r - mq);
        STEP_3C: ns3_r <= sat18(t_r - mq);
        STEP_4C: ns4_r <= sat18(t_r - mq);
        STEP_KD: ns4_r <= sat18(W'(ns4_r) - mq);
        default: begin
        end
      endcase
    end
    if (cmd.commit) begin
      lp_r <= ns4_r;
      bp_r <= sat18(W'(x_r) - W'(ns4_r));
      hp_r <= sat18(40'sd3 * (W'(ns3_r) - W'(ns4_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= CUTOFF_RST;
      resonance_r <= '0;
      prev_r      <= PREV_RST;
      st1_r       <= PREV_RST;
      st2_r       <= '0;
      st3_r       <= '0;
      st4_r       <= '0;
      gain_r      <= '0;
      fb_r        <= '0;
      decay_r     <= '0;
      bpos_r      <= '0;
      uph_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_CUTOFF:    cutoff_r    <= cfg_wdata;
          REG_RESONANCE: resonance_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (cmd.run && cmd.step == STEP_C6) begin
        gain_r  <= sat18(pc_r);
        decay_r <= sat18(40'sd2 * pc_r - ONE_Q14);
        fb_r    <= sat18(qw);
      end
      if (cmd.commit) begin
        prev_r <= x_r;
        st1_r  <= ns1_r;
        st2_r  <= ns2_r;
        st3_r  <= ns3_r;
        st4_r  <= ns4_r;
        if (bpos_inc >= BPW'(BLOCK_LEN)) begin
          bpos_r <= '0;
          uph_r  <= '0;
        end else begin
          bpos_r <= bpos_inc;
          uph_r  <= (uph_inc >= UPW'(UPDATE_INTERVAL)) ? '0 : uph_inc;
        end
      end
    end
  end

  assign out_lowpass_out  = lp_r;
  assign out_bandpass_out = bp_r;
  assign out_highpass_out = hp_r;

endmodule
`default_nettype wire

// ----- rtl/four_pole_ladder_filter.sv -----
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    sample_in, cutoff_cv, emphasis_cv
// out_      output     out_valid/out_stall  lowpass_out, bandpass_out, highpass_out
// cfg_      input      cfg_we               cfg_addr, cfg_wdata
//
// One shared 27x27 multiplier is sequenced by the controller, one step a cycle.
// An item runs steps FB to FIN after acceptance, or C0 to FIN when the coefficients
// are recomputed (seven extra steps); a new item is taken only after the commit.
// Reset is synchronous; no clearing pass is needed.
// A stalled result is held in the output register; the controller waits at its
// last step until the register is free.
`default_nettype none
module four_pole_ladder_filter
  import mlf_pkg::*;
#(
  parameter int BLOCK_LEN       = BLOCK_LEN_DEF,
  parameter int UPDATE_INTERVAL = UPDATE_INTERVAL_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_AW-1:0]    cfg_addr,
  input  wire logic [CW-1:0]        cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic signed [DW-1:0] in_sample_in,
  input  wire logic signed [DW-1:0] in_cutoff_cv,
  input  wire logic signed [DW-1:0] in_emphasis_cv,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic signed [DW-1:0]      out_lowpass_out,
  output logic signed [DW-1:0]      out_bandpass_out,
  output logic signed [DW-1:0]      out_highpass_out
);

  mlf_cmd_t  cmd;
  mlf_stat_t stat;

  mlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mlf_datapath #(
    .BLOCK_LEN       (BLOCK_LEN),
    .UPDATE_INTERVAL (UPDATE_INTERVAL)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_sample_in     (in_sample_in),
    .in_cutoff_cv     (in_cutoff_cv),
    .in_emphasis_cv   (in_emphasis_cv),
    .cmd              (cmd),
    .stat             (stat),
    .out_lowpass_out  (out_lowpass_out),
    .out_bandpass_out (out_bandpass_out),
    .out_highpass_out (out_highpass_out)
  );

endmodule
`default_nettype wire

// ----- dv/tb_four_pole_ladder_filter.sv -----
`default_nettype none
module tb_four_pole_ladder_filter
  import mlf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLK = 256;
  localparam int UPD = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_CUTOFF;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_sample_in = '0;
  logic signed [DW-1:0] in_cutoff_cv = '0;
  logic signed [DW-1:0] in_emphasis_cv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_lowpass_out;
  logic signed [DW-1:0] out_bandpass_out;
  logic signed [DW-1:0] out_highpass_out;

  four_pole_ladder_filter i_dut (.*);

  typedef struct packed {
    logic signed [DW-1:0] lp;
    logic signed [DW-1:0] bp;
    logic signed [DW-1:0] hp;
  } filt_out_t;

  filt_out_t expected_q[$];
  int errors = 0;
  bit idle_en = 1'b1;

  longint m_cutoff, m_reson;
  longint m_prev, m_s1, m_s2, m_s3, m_s4, m_gain, m_fb, m_decay;
  int m_pos, m_phase;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint fshr(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint mq(longint a, longint b);
    return fshr(a * b, 14);
  endfunction

  function automatic longint clip18(longint x);
    if (x > 131071) return 131071;
    if (x < -131072) return -131072;
    return x;
  endfunction

  function automatic void filter_reset();
    m_cutoff = 8192; m_reson = 0;
    m_prev = 1638; m_s1 = 1638; m_s2 = 0; m_s3 = 0; m_s4 = 0;
    m_gain = 0; m_fb = 0; m_decay = 0; m_pos = 0; m_phase = 0;
  endfunction

  function automatic filt_out_t filter_step(longint smp, longint ccv, longint ecv);
    longint fc, r, p, inner, q, x, s1, s2, s3, s4, lp;
    filt_out_t o;
    if (m_phase == 0) begin
      fc = m_cutoff + ccv;
      fc = (fc < 0) ? 0 : fshr(fc, 2);
      r = 16384 - fc;
      p = fc + mq(mq(fc, r), 13107);
      inner = 16384 - r + mq(mq(r, r), 91750);
      q = 6 * (m_reson + ecv) - 3 * 16384 + 16384 + fshr(mq(r, inner), 1);
      m_gain = clip18(p);
      m_decay = clip18(2 * p - 16384);
      m_fb = clip18(q);
    end
    x = smp - mq(m_fb, m_s4);
    if (x > 16384) x = 16384;
    if (x < -16384) x = -16384;
    s1 = clip18(mq(x + m_prev, m_gain) - mq(m_s1, m_decay));
    s2 = clip18(mq(s1 + m_s1, m_gain) - mq(m_s2, m_decay));
    s3 = clip18(mq(s2 + m_s2, m_gain) - mq(m_s3, m_decay));
    s4 = clip18(mq(s3 + m_s3, m_gain) - mq(m_s4, m_decay));
    s4 = clip18(s4 - mq(mq(mq(s4, s4), s4), 2731));
    m_s1 = s1; m_s2 = s2; m_s3 = s3; m_s4 = s4; m_prev = x;
    lp = s4;
    o.lp = DW'(lp);
    o.bp = DW'(clip18(x - lp));
    o.hp = DW'(clip18(3 * (s3 - lp)));
    m_pos++;
    if (m_pos >= BLK) begin
      m_pos = 0; m_phase = 0;
    end else begin
      m_phase++;
      if (m_phase >= UPD) m_phase = 0;
    end
    return o;
  endfunction

  // stall the result side in bursts
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    filt_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_lowpass_out !== e.lp) begin
          $error("lowpass_out exp %0d got %0d", e.lp, out_lowpass_out); errors++;
        end
        if (out_bandpass_out !== e.bp) begin
          $error("bandpass_out exp %0d got %0d", e.bp, out_bandpass_out); errors++;
        end
        if (out_highpass_out !== e.hp) begin
          $error("highpass_out exp %0d got %0d", e.hp, out_highpass_out); errors++;
        end
      end
    end
  end

  task automatic send_sample(logic signed [DW-1:0] smp, logic signed [DW-1:0] ccv,
                             logic signed [DW-1:0] ecv);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= smp;
    in_cutoff_cv <= ccv;
    in_emphasis_cv <= ecv;
    do @(posedge clk); while (in_stall);
    expected_q = {expected_q, filter_step(smp, ccv, ecv)};
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CW-1:0] val);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CUTOFF) m_cutoff = val;
    else m_reson = val;
  endtask

  function automatic logic signed [DW-1:0] rnd18();
    case ($urandom_range(0, 5))
      0: return 18'sh1FFFF;
      1: return 18'sh20000;
      2: return 18'(int'($urandom_range(0, 32768)) - 16384);
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [DW-1:0] ext[4];
    ext = '{18'sh1FFFF, 18'sh20000, 18'sd0, 18'sd16384};
    for (int i = 0; i < 4; i++) send_sample(ext[i], 18'sd0, 18'sd0);
    for (int i = 0; i < 4; i++) send_sample(18'sd8000, ext[i], ext[3 - i]);
    for (int i = 0; i < 12; i++) send_sample(-18'sd8000 + 18'(i * 1500), 18'sd0, 18'sd0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_sample(rnd18(), rnd18(), rnd18());
  endtask

  task automatic test_settings();
    write_reg(REG_CUTOFF, 15'd0);     write_reg(REG_RESONANCE, 15'd16384);
    test_random(100);
    write_reg(REG_CUTOFF, 15'd16384); write_reg(REG_RESONANCE, 15'd0);
    test_random(100);
    write_reg(REG_CUTOFF, 15'h7FFF);  write_reg(REG_RESONANCE, 15'h7FFF);
    test_random(60);
    write_reg(REG_CUTOFF, 15'($urandom_range(0, 16384)));
    write_reg(REG_RESONANCE, 15'($urandom_range(0, 8192)));
    test_random(150);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    test_random(210);
  endtask

  initial begin
    filter_reset();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_settings();
    test_no_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
